// ----- hw/rtl/mcdt_pkg.sv -----
// Shared types and constants for the masked class-code device table.
// Holds opcode and result-kind codes, address field masks and the result record.
// No dependencies.
package mcdt_pkg;

   localparam int unsigned REQ_DATA_W = 104;
   localparam int unsigned RSP_DATA_W = 56;

   localparam logic [1:0] OP_INSERT     = 2'd0;
   localparam logic [1:0] OP_SEARCH     = 2'd1;
   localparam logic [1:0] OP_ENTRY_ADDR = 2'd2;
   localparam logic [1:0] OP_COMPOSE    = 2'd3;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_MATCH  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ADDR   = 2'd3;

   localparam logic [31:0] ADDR_REG_MASK  = 32'h0000_00FC;
   localparam logic [31:0] ADDR_FUNC_MASK = 32'h0000_0700;
   localparam logic [31:0] ADDR_DEV_MASK  = 32'h0000_F800;
   localparam logic [31:0] ADDR_BUS_MASK  = 32'h00FF_0000;
   localparam int unsigned ENABLE_SHIFT   = 31;
   localparam logic [7:0]  LOC_ALL_ONES   = 8'hFF;

   typedef struct packed {
      logic [31:0] class_code;
      logic [15:0] location;
   } entry_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  match_id;
      logic [8:0]  hit_count;
      logic [31:0] config_address;
      logic        last;
   } result_type;

   function automatic logic [31:0] compose_address(
      input logic       en,
      input logic [7:0] bus,
      input logic [4:0] dev,
      input logic [2:0] fn,
      input logic [7:0] offset
   );
      logic [31:0] a;
      a = 32'(en) << ENABLE_SHIFT;
      a = a | ((32'(bus) << 16) & ADDR_BUS_MASK);
      a = a | ((32'(dev) << 11) & ADDR_DEV_MASK);
      a = a | ((32'(fn) << 8) & ADDR_FUNC_MASK);
      a = a | (32'(offset) & ADDR_REG_MASK);
      return a;
   endfunction

endpackage

// ----- hw/rtl/mcdt_table.sv -----
// Device table storage: class-code and location memories with per-entry valid bits.
// Unwritten entries read as all ones. Depends on mcdt_pkg.
module mcdt_table
   import mcdt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 256,
   parameter int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [23:0]      wr_class,
   input  logic [15:0]      wr_location,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry
);

   logic [23:0]              class_mem [TABLE_ENTRIES];
   logic [15:0]              loc_mem   [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic                     rd_valid_ff;
   logic [23:0]              rd_class_ff;
   logic [15:0]              rd_loc_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         class_mem[wr_addr] <= wr_class;
         loc_mem[wr_addr]   <= wr_location;
      end
      rd_class_ff <= class_mem[rd_addr];
      rd_loc_ff   <= loc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_entry.class_code = {8'h00, rd_class_ff};
         rd_entry.location   = rd_loc_ff;
      end else begin
         rd_entry.class_code = '1;
         rd_entry.location   = '1;
      end
   end

endmodule

// ----- hw/rtl/masked_class_code_device_table_unit.sv -----
// Top level of the masked class-code device table: request decode, scan sequencer,
// result register. Depends on mcdt_pkg and mcdt_table.
//
//  channel | ports                  | tuser          | tdata / tlast
//  request | req_tvalid/tready      | opcode         | entry, class, mask, limit, bdf, reg, en
//  result  | rsp_tvalid/tready      | result_kind    | match_id, hit_count, address; last
//
// Insert and compose answer straight from the request, entry address via ST_LOOKUP (table read).
// Search reads one entry per cycle through the single table read port, except while a
// match waits on a full result register, and ends with a done result.
// Reset is synchronous; the table needs no clearing pass (valid bits per entry).
// Backpressure on the result side stalls the scan in place when a match is to be emitted.
module masked_class_code_device_table_unit
   import mcdt_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = 256,
   parameter int unsigned MAX_EMITTED = 63
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] entry_id, [39:8] class_code, [71:40] class_mask, [77:72] buffer_limit,
   // [85:78] bus_number, [90:86] device_number, [93:91] function_number,
   // [101:94] register_offset, [102] enable_bit, [103] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] match_id, [16:8] hit_count, [48:17] config_address, [55:49] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [8:0]       hits_ff, hits_in;
   logic [5:0]       cap_ff, cap_in;
   logic [31:0]      cc_ff, cc_in;
   logic [31:0]      mask_ff, mask_in;
   logic             en_ff, en_in;
   logic [7:0]       reg_ff, reg_in;
   logic             inrange_ff, inrange_in;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_res_ff;

   logic [1:0]       req_opcode;
   logic [7:0]       req_entry_id;
   logic [31:0]      req_class_code;
   logic [31:0]      req_class_mask;
   logic [5:0]       req_buffer_limit;
   logic [7:0]       req_bus_number;
   logic [4:0]       req_device_number;
   logic [2:0]       req_function_number;
   logic [7:0]       req_register_offset;
   logic             req_enable_bit;

   logic             req_fire;
   logic             can_emit;
   logic             req_inrange;
   logic [IDX_W-1:0] req_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   entry_type        rd_entry;
   logic             scan_match;
   logic             scan_emit;
   logic             scan_stall;
   logic             scan_last;
   logic             emit;
   result_type       emit_res;
   logic [15:0]      lookup_loc;

   assign req_opcode          = req_tuser;
   assign req_entry_id        = req_tdata[7:0];
   assign req_class_code      = req_tdata[39:8];
   assign req_class_mask      = req_tdata[71:40];
   assign req_buffer_limit    = req_tdata[77:72];
   assign req_bus_number      = req_tdata[85:78];
   assign req_device_number   = req_tdata[90:86];
   assign req_function_number = req_tdata[93:91];
   assign req_register_offset = req_tdata[101:94];
   assign req_enable_bit      = req_tdata[102];

   assign can_emit    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && can_emit;
   assign req_fire    = req_tvalid && req_tready;
   assign req_inrange = ({1'b0, req_entry_id} < 9'(TABLE_ENTRIES));
   assign req_idx     = req_entry_id[IDX_W-1:0];

   assign scan_match = (((rd_entry.class_code ^ cc_ff) & mask_ff) == 32'h0);
   assign scan_emit  = scan_match && (hits_ff < {3'b000, cap_ff});
   assign scan_stall = scan_emit && !can_emit;
   assign scan_last  = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign lookup_loc = inrange_ff ? rd_entry.location : {LOC_ALL_ONES, LOC_ALL_ONES};

   mcdt_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (req_idx),
      .wr_class   (req_class_code[23:0]),
      .wr_location({req_bus_number, req_device_number, req_function_number}),
      .rd_addr    (rd_addr),
      .rd_entry   (rd_entry)
   );

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      hits_in    = hits_ff;
      cap_in     = cap_ff;
      cc_in      = cc_ff;
      mask_in    = mask_ff;
      en_in      = en_ff;
      reg_in     = reg_ff;
      inrange_in = inrange_ff;
      rd_addr    = addr_ff;
      wr_en      = 1'b0;
      emit       = 1'b0;
      emit_res   = '0;
      case (state_ff)
         ST_IDLE: begin
            rd_addr = req_idx;
            if (req_fire) begin
               case (req_opcode)
                  OP_INSERT: begin
                     wr_en         = req_inrange;
                     emit          = 1'b1;
                     emit_res.kind = KIND_INSERT;
                     emit_res.last = 1'b1;
                  end
                  OP_SEARCH: begin
                     rd_addr  = '0;
                     addr_in  = '0;
                     hits_in  = '0;
                     cc_in    = req_class_code;
                     mask_in  = req_class_mask;
                     cap_in   = (32'(req_buffer_limit) > MAX_EMITTED) ?
                                6'(MAX_EMITTED) : req_buffer_limit;
                     state_in = ST_SCAN;
                  end
                  OP_ENTRY_ADDR: begin
                     addr_in    = req_idx;
                     inrange_in = req_inrange;
                     en_in      = req_enable_bit;
                     reg_in     = req_register_offset;
                     state_in   = ST_LOOKUP;
                  end
                  OP_COMPOSE: begin
                     emit                    = 1'b1;
                     emit_res.kind           = KIND_ADDR;
                     emit_res.last           = 1'b1;
                     emit_res.config_address = compose_address(req_enable_bit,
                        req_bus_number, req_device_number, req_function_number,
                        req_register_offset);
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LOOKUP: begin
            if (can_emit) begin
               emit                    = 1'b1;
               emit_res.kind           = KIND_ADDR;
               emit_res.last           = 1'b1;
               emit_res.config_address = {en_ff, 7'b0000000, lookup_loc,
                                          reg_ff & ADDR_REG_MASK[7:0]};
               state_in                = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!scan_stall) begin
               hits_in = hits_ff + 9'(scan_match);
               if (scan_emit) begin
                  emit              = 1'b1;
                  emit_res.kind     = KIND_MATCH;
                  emit_res.match_id = 8'(addr_ff);
               end
               if (scan_last) begin
                  state_in = ST_DONE;
               end else begin
                  addr_in = addr_ff + 1'b1;
                  rd_addr = addr_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (can_emit) begin
               emit               = 1'b1;
               emit_res.kind      = KIND_DONE;
               emit_res.hit_count = hits_ff;
               emit_res.last      = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff     <= cap_in;
      cc_ff      <= cc_in;
      mask_ff    <= mask_in;
      en_ff      <= en_in;
      reg_ff     <= reg_in;
      inrange_ff <= inrange_in;
      if (emit) begin
         rsp_res_ff <= emit_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.kind;
   assign rsp_tlast  = rsp_res_ff.last;
   assign rsp_tdata  = {7'b0000000, rsp_res_ff.config_address, rsp_res_ff.hit_count,
                        rsp_res_ff.match_id};

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   a_emit_within_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && emit) |-> (hits_ff < {3'b000, cap_ff}))
      else $error("match result beyond emit limit");

   a_scan_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !scan_stall && !scan_last) |=>
      (state_ff == ST_SCAN && addr_ff == IDX_W'($past(addr_ff) + 1'b1)))
      else $error("scan address did not advance");

   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_stall) |=>
      (state_ff == ST_SCAN && $stable(addr_ff) && $stable(hits_ff)))
      else $error("scan moved while stalled");

endmodule
